FILE: rtl/core/glvg_pkg.sv
// Shared types and constants of the graph Laplacian value generator.
`timescale 1ns / 1ps

package glvg_pkg;

   localparam int VERTICES_DEFAULT = 1024;

   localparam int IDX_W       = 11;
   localparam int VALUE_W     = 48;
   localparam int DEGREE_W    = 16;
   localparam int COUNT_W     = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // func codes
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_COUNT  = 2'd1;
   localparam logic [1:0] FUNC_EMIT   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BETA_OFFSET    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_BASE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMMETRIC_MODE = 3'd4;

   // register reset values: 10.0 and 1.0 in Q16.16
   localparam logic [31:0] ALPHA_GAIN_RESET  = 32'd655360;
   localparam logic [31:0] BETA_OFFSET_RESET = 32'd65536;
   localparam logic [3:0]  BLOCK_SIZE_RESET  = 4'd1;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   typedef struct packed {
      logic [1:0]       func;
      logic [IDX_W-1:0] row_index;
      logic [IDX_W-1:0] col_index;
      logic             last_edge;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic                      on_diagonal;
      logic [COUNT_W-1:0]        diagonal_count;
      logic                      status;
      logic                      pass_done;
      logic                      last;
   } rsp_type;

endpackage

FILE: rtl/core/graph_laplacian_value_generator.sv
// Top level of the graph Laplacian value generator (M = alpha * D - beta * A).
//
// Usage:
//   req_*  : edge transactions (func, row_index, col_index, last_edge), valid/stall.
//   rsp_*  : result transactions, valid/stall; every request gives one result,
//            except an in-range emit-pass edge, which gives (effective block size)^2 results
//            (column offset outer, row offset inner), the final one with last set.
//   csr_*  : register writes (index, data), valid/ready; always ready. Write only
//            while the block is idle.
// Sequence (one request in flight at a time, req_stall is high while busy):
//   count edge : states READ, UPDATE, then RESP; in symmetric mode an off-diagonal
//                edge runs READ and UPDATE per endpoint (read/update of the degree RAM).
//   emit edge  : degree read, multiply, then one value per cycle while the output slot is free.
//   clear      : one degree RAM entry per cycle over all VERTICES entries, then the result.
//   error / unused func : result loaded from RESP once the output slot is free.
// Reset: registers take their defaults and a clearing pass zeroes the degree RAM;
//   req_stall stays high meanwhile.
// Receiver stall: the output register holds its transaction; the sequencer waits
//   for a free output slot before it loads the next result.
`timescale 1ns / 1ps

module graph_laplacian_value_generator #(
   parameter int VERTICES = glvg_pkg::VERTICES_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  glvg_pkg::req_type                       req_data,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output glvg_pkg::rsp_type                       rsp_data,
   // register write channel
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [glvg_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [glvg_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   import glvg_pkg::*;

   localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(VERTICES - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_MULT,
      ST_EMIT,
      ST_RESP
   } state_type;

   // sequencer state
   state_type state_ff, state_in;
   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic clr_rsp_ff, clr_rsp_in;

   // current transaction
   logic [1:0]    func_ff, func_in;
   logic          last_ff, last_in;
   logic [AW-1:0] ig_ff, ig_in;
   logic [AW-1:0] jg_ff, jg_in;
   logic          eq_ff, eq_in;
   logic          status_ff, status_in;
   logic          second_ff, second_in;
   logic [VALUE_W-1:0] prod_ff, prod_in;
   logic [2:0]    ii_ff, ii_in;
   logic [2:0]    jj_ff, jj_in;

   logic [COUNT_W-1:0] diag_cnt_ff, diag_cnt_in;

   // output register
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // configuration
   logic [31:0] alpha_ff, alpha_in;
   logic [31:0] beta_ff, beta_in;
   logic [3:0]  bsize_ff, bsize_in;
   logic        base_ff, base_in;
   logic        sym_ff, sym_in;

   // degree RAM port
   logic [AW-1:0]       ram_addr;
   logic                ram_we;
   logic [DEGREE_W-1:0] ram_wdata;
   logic [DEGREE_W-1:0] ram_rdata;

   logic req_fire;
   logic slot_free;
   logic [3:0] dof;
   logic [2:0] dof_m1;
   logic [3:0] amount;
   logic [DEGREE_W:0] deg_sum;
   logic [IDX_W:0] row_sub, col_sub;
   logic row_bad, col_bad;
   logic [VALUE_W-1:0] neg_beta;
   logic emit_diag;
   logic emit_fin;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // effective block size: zero acts as one, above eight acts as eight
   always_comb begin
      if (bsize_ff == 4'd0) begin
         dof = 4'd1;
      end else if (bsize_ff > 4'd8) begin
         dof = 4'd8;
      end else begin
         dof = bsize_ff;
      end
   end
   assign dof_m1 = 3'(dof - 4'd1);

   // base subtraction and range check of the incoming indices
   assign row_sub = {1'b0, req_data.row_index} - {{IDX_W{1'b0}}, base_ff};
   assign col_sub = {1'b0, req_data.col_index} - {{IDX_W{1'b0}}, base_ff};
   assign row_bad = row_sub[IDX_W] || ({21'd0, row_sub[IDX_W-1:0]} >= 32'(VERTICES));
   assign col_bad = col_sub[IDX_W] || ({21'd0, col_sub[IDX_W-1:0]} >= 32'(VERTICES));

   // shared saturating adder on the degree read back from the RAM
   assign amount  = eq_ff ? (dof - 4'd1) : dof;
   assign deg_sum = {1'b0, ram_rdata} + {{(DEGREE_W-3){1'b0}}, amount};

   assign neg_beta  = '0 - {{(VALUE_W-32){1'b0}}, beta_ff};
   assign emit_diag = eq_ff && (ii_ff == jj_ff);
   assign emit_fin  = (ii_ff == dof_m1) && (jj_ff == dof_m1);

   // RAM address and write port: sweep address while clearing, else the endpoint
   always_comb begin
      ram_addr  = second_ff ? ig_ff : jg_ff;
      ram_we    = 1'b0;
      ram_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         ram_addr = clr_cnt_ff;
         ram_we   = 1'b1;
      end else if (state_ff == ST_UPDATE) begin
         ram_we    = 1'b1;
         ram_wdata = deg_sum[DEGREE_W] ? {DEGREE_W{1'b1}} : deg_sum[DEGREE_W-1:0];
      end
   end

   glvg_ram #(
      .WIDTH (DEGREE_W),
      .DEPTH (VERTICES)
   ) u_degree_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // next-state logic of the sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_rsp_in   = clr_rsp_ff;
      func_in      = func_ff;
      last_in      = last_ff;
      ig_in        = ig_ff;
      jg_in        = jg_ff;
      eq_in        = eq_ff;
      status_in    = status_ff;
      second_in    = second_ff;
      prod_in      = prod_ff;
      ii_in        = ii_ff;
      jj_in        = jj_ff;
      diag_cnt_in  = diag_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      alpha_in     = alpha_ff;
      beta_in      = beta_ff;
      bsize_in     = bsize_ff;
      base_in      = base_ff;
      sym_in       = sym_ff;

      // drop the result once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         case (csr_index)
            CSR_ALPHA_GAIN:     alpha_in = csr_wdata;
            CSR_BETA_OFFSET:    beta_in  = csr_wdata;
            CSR_BLOCK_SIZE:     bsize_in = csr_wdata[3:0];
            CSR_INDEX_BASE:     base_in  = csr_wdata[0];
            CSR_SYMMETRIC_MODE: sym_in   = csr_wdata[0];
            default:            ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_ADDR) begin
               clr_cnt_in = '0;
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               func_in   = req_data.func;
               last_in   = req_data.last_edge;
               ig_in     = AW'(row_sub[IDX_W-1:0]);
               jg_in     = AW'(col_sub[IDX_W-1:0]);
               eq_in     = (row_sub == col_sub);
               second_in = 1'b0;
               status_in = 1'b0;
               case (req_data.func)
                  FUNC_CLEAR: begin
                     diag_cnt_in = '0;
                     clr_cnt_in  = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  FUNC_COUNT, FUNC_EMIT: begin
                     if (row_bad || col_bad) begin
                        status_in = 1'b1;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_READ: begin
            state_in = (func_ff == FUNC_COUNT) ? ST_UPDATE : ST_MULT;
         end

         ST_UPDATE: begin
            if (eq_ff && (diag_cnt_ff != {COUNT_W{1'b1}})) begin
               diag_cnt_in = diag_cnt_ff + 1'b1;
            end
            // symmetric mode: advance to the row endpoint
            if (!eq_ff && sym_ff && !second_ff) begin
               second_in = 1'b1;
               state_in  = ST_READ;
            end else begin
               second_in = 1'b0;
               state_in  = ST_RESP;
            end
         end

         ST_MULT: begin
            prod_in = {{(VALUE_W-32){1'b0}}, alpha_ff} *
                      {{(VALUE_W-DEGREE_W){1'b0}}, ram_rdata};
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.on_diagonal    = emit_diag;
               rsp_in.diagonal_count = diag_cnt_ff;
               rsp_in.status         = 1'b0;
               rsp_in.pass_done      = emit_fin && last_ff;
               rsp_in.last           = emit_fin;
               if (emit_diag) begin
                  rsp_in.value_out = $signed(prod_ff[VALUE_W-1] ? VALUE_MAX : prod_ff);
               end else begin
                  rsp_in.value_out = $signed(neg_beta);
               end
               // row offset inner, column offset outer
               if (emit_fin) begin
                  ii_in    = '0;
                  jj_in    = '0;
                  state_in = ST_IDLE;
               end else if (ii_ff == dof_m1) begin
                  ii_in = '0;
                  jj_in = jj_ff + 1'b1;
               end else begin
                  ii_in = ii_ff + 1'b1;
               end
            end
         end

         ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.value_out      = '0;
               rsp_in.on_diagonal    = 1'b0;
               rsp_in.diagonal_count = diag_cnt_ff;
               rsp_in.status         = status_ff;
               rsp_in.pass_done      = last_ff;
               rsp_in.last           = 1'b1;
               state_in              = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         second_ff    <= 1'b0;
         ii_ff        <= '0;
         jj_ff        <= '0;
         diag_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         alpha_ff     <= ALPHA_GAIN_RESET;
         beta_ff      <= BETA_OFFSET_RESET;
         bsize_ff     <= BLOCK_SIZE_RESET;
         base_ff      <= 1'b0;
         sym_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         second_ff    <= second_in;
         ii_ff        <= ii_in;
         jj_ff        <= jj_in;
         diag_cnt_ff  <= diag_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         alpha_ff     <= alpha_in;
         beta_ff      <= beta_in;
         bsize_ff     <= bsize_in;
         base_ff      <= base_in;
         sym_ff       <= sym_in;
      end
      func_ff   <= func_in;
      last_ff   <= last_in;
      ig_ff     <= ig_in;
      jg_ff     <= jg_in;
      eq_ff     <= eq_in;
      status_ff <= status_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

`ifndef SYNTHESIS
   // a diagonal value is never an error result and never negative
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.on_diagonal) |-> (!rsp_ff.status && !rsp_ff.value_out[VALUE_W-1]))
      else $error("diagonal result with error status or negative value");

   // the diagonal counter moves only on a count update or a clear command
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (diag_cnt_ff != $past(diag_cnt_ff))) |->
      ($past(state_ff) == ST_UPDATE || $past(req_fire)))
      else $error("diagonal counter changed outside count update or clear");

   // emit position is back at zero outside the emit sequence
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EMIT) |-> (ii_ff == 3'd0 && jj_ff == 3'd0))
      else $error("emit position not zero between transactions");
`endif

endmodule

FILE: rtl/core/glvg_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module glvg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: dv/glvg_value_checker.sv
// Channel monitor and value predictor for the graph Laplacian value generator.
`timescale 1ns / 1ps

module glvg_value_checker #(
   parameter int VERTICES = glvg_pkg::VERTICES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  glvg_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  glvg_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [glvg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [glvg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  result_count
);

   import glvg_pkg::*;

   // mirrored registers
   logic [31:0]         alpha_q;
   logic [31:0]         beta_q;
   logic [3:0]          block_size_q;
   logic                index_base_q;
   logic                symmetric_q;

   // mirrored state
   logic [DEGREE_W-1:0] degree_tbl [VERTICES];
   logic [COUNT_W-1:0]  diag_tally;

   rsp_type             expected_values [$];
   rsp_type             oldest;

   task automatic queue_result(input logic [VALUE_W-1:0] value, input logic diag,
                               input logic bad_index, input logic done,
                               input logic closing);
      rsp_type r;
      r.value_out      = value;
      r.on_diagonal    = diag;
      r.diagonal_count = diag_tally;
      r.status         = bad_index;
      r.pass_done      = done;
      r.last           = closing;
      expected_values.push_back(r);
   endtask

   task automatic bump_degree(input int vertex, input int unsigned amount);
      int unsigned sum;
      sum = 32'(degree_tbl[vertex]) + amount;
      degree_tbl[vertex] = (sum > 65535) ? 16'hFFFF : sum[15:0];
   endtask

   task automatic predict_laplacian_values(input req_type item);
      int unsigned        dof;
      int                 ig, jg, ii, jj;
      logic [63:0]        product;
      logic [VALUE_W-1:0] value;
      logic               diag, closing;
      if (block_size_q == 4'd0)     dof = 1;
      else if (block_size_q > 4'd8) dof = 8;
      else                          dof = 32'(block_size_q);
      ig = int'(item.row_index);
      jg = int'(item.col_index);
      ig = ig - int'(index_base_q);
      jg = jg - int'(index_base_q);

      if (item.func == FUNC_CLEAR) begin
         foreach (degree_tbl[v]) degree_tbl[v] = '0;
         diag_tally = '0;
         queue_result('0, 1'b0, 1'b0, item.last_edge, 1'b1);
      end else if (item.func == FUNC_UNUSED) begin
         queue_result('0, 1'b0, 1'b0, item.last_edge, 1'b1);
      end else if (ig < 0 || jg < 0 || ig >= VERTICES || jg >= VERTICES) begin
         // bad index: flag it, leave the state alone
         queue_result('0, 1'b0, 1'b1, item.last_edge, 1'b1);
      end else if (item.func == FUNC_COUNT) begin
         if (ig != jg) begin
            bump_degree(jg, dof);
            if (symmetric_q) bump_degree(ig, dof);
         end else begin
            bump_degree(jg, dof - 1);
            if (diag_tally != '1) diag_tally = diag_tally + 1'b1;
         end
         queue_result('0, 1'b0, 1'b0, item.last_edge, 1'b1);
      end else begin
         // emit: column offset outer, row offset inner
         for (jj = 0; jj < dof; jj++) begin
            for (ii = 0; ii < dof; ii++) begin
               diag = (ig == jg) && (ii == jj);
               if (diag) begin
                  product = 64'(alpha_q) * 64'(degree_tbl[jg]);
                  value = (product > {16'h0, VALUE_MAX}) ? VALUE_MAX : product[VALUE_W-1:0];
               end else begin
                  value = '0;
                  value = value - VALUE_W'(beta_q);
               end
               closing = (jj == dof - 1) && (ii == dof - 1);
               queue_result(value, diag, 1'b0, closing & item.last_edge, closing);
            end
         end
      end
   endtask

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         alpha_q      = ALPHA_GAIN_RESET;
         beta_q       = BETA_OFFSET_RESET;
         block_size_q = BLOCK_SIZE_RESET;
         index_base_q = 1'b0;
         symmetric_q  = 1'b0;
         foreach (degree_tbl[v]) degree_tbl[v] = '0;
         diag_tally   = '0;
         expected_values.delete();
         fail_count   = 0;
         result_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ALPHA_GAIN:     alpha_q      = csr_wdata;
               CSR_BETA_OFFSET:    beta_q       = csr_wdata;
               CSR_BLOCK_SIZE:     block_size_q = csr_wdata[3:0];
               CSR_INDEX_BASE:     index_base_q = csr_wdata[0];
               CSR_SYMMETRIC_MODE: symmetric_q  = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_values.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected result, expected none actual %0h",
                        $time, rsp_data);
            end else begin
               oldest = expected_values.pop_front();
               compare_field("value_out", {16'h0, oldest.value_out},
                             {16'h0, rsp_data.value_out});
               compare_field("on_diagonal", 64'(oldest.on_diagonal),
                             64'(rsp_data.on_diagonal));
               compare_field("diagonal_count", 64'(oldest.diagonal_count),
                             64'(rsp_data.diagonal_count));
               compare_field("status", 64'(oldest.status), 64'(rsp_data.status));
               compare_field("pass_done", 64'(oldest.pass_done), 64'(rsp_data.pass_done));
               compare_field("last", 64'(oldest.last), 64'(rsp_data.last));
            end
         end
         if (req_valid && !req_stall) predict_laplacian_values(req_data);
      end
      pending_count <= expected_values.size();
   end

endmodule

FILE: dv/tb_top.sv
// Top-level testbench: stimulus, traffic shaping and verdict for the Laplacian generator.
`timescale 1ns / 1ps

module tb_top;

   import glvg_pkg::*;

   // Generous cap: even if every transaction were a clear or a 64-result emit
   // under heavy receiver stalls, the run stays well below this.
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_OFF_CYCLES = 200;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count, pending_count, result_count;

   // traffic shaping knobs, percent of cycles spent idle
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // long receiver hold-off: stimulus bumps the request count, the receiver serves it
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   int items_sent  = 0;
   int cycle_count = 0;
   logic cur_base  = 1'b0;

   always #10 clock = ~clock;

   graph_laplacian_value_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   glvg_value_checker value_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   // Receiver: random stall at the current rate, or a long hold-off when one is
   // requested. The hold-off keeps the output register full so the block backs
   // up and stalls its input while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_stall    <= 1'b1;
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_OFF_CYCLES - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, pending_count);
      $display("graph_laplacian_value_generator regression: fail");
      $finish;
   end

   // Offer one edge transaction and hold it until the block takes it. Valid stays
   // high on return so a back-to-back transaction needs no second assignment.
   task automatic send_item(input logic [1:0] fn, input int row, input int col,
                            input bit fin);
      req_type item;
      item.func      = fn;
      item.row_index = row[IDX_W-1:0];
      item.col_index = col[IDX_W-1:0];
      item.last_edge = fin;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // Drop valid and wait until every predicted result has been seen.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Rewrite all five registers; call only while the block is idle.
   task automatic program_regs(input logic [31:0] alpha, input logic [31:0] beta,
                               input logic [3:0] bsize, input logic base,
                               input logic sym);
      write_reg(CSR_ALPHA_GAIN, alpha);
      write_reg(CSR_BETA_OFFSET, beta);
      write_reg(CSR_BLOCK_SIZE, {28'h0, bsize});
      write_reg(CSR_INDEX_BASE, {31'h0, base});
      write_reg(CSR_SYMMETRIC_MODE, {31'h0, sym});
      csr_valid <= 1'b0;
      cur_base = base;
   endtask

   // Q16.16 gain biased toward the ends of its range.
   function automatic logic [31:0] pick_gain();
      logic [31:0] g;
      g = $urandom();
      case ($urandom_range(3))
         0: g = 32'd1;
         1: g = 32'hFFFF_FFFF;
         default: if (g == 32'd0) g = 32'd1;
      endcase
      return g;
   endfunction

   // Noise: unused code, or count/emit on indices across the full field width.
   task automatic send_stray_item();
      case ($urandom_range(2))
         0: send_item(FUNC_UNUSED, $urandom_range(2047), $urandom_range(2047),
                      1'($urandom_range(1)));
         1: send_item(FUNC_COUNT, $urandom_range(2047), $urandom_range(2047),
                      1'($urandom_range(1)));
         default: send_item(FUNC_EMIT, $urandom_range(2047), $urandom_range(2047),
                            1'($urandom_range(1)));
      endcase
   endtask

   // Well-formed traffic: optional clear, a count pass over a handful of edges,
   // then the emit pass over the same edges, with stray items mixed in.
   task automatic run_edge_batches(input int quota, input bit with_hold_off,
                                   input bit with_pause);
      int first_item, n, k;
      int row_of [8];
      int col_of [8];
      bit first_batch;
      first_item  = items_sent;
      first_batch = 1'b1;
      while (items_sent - first_item < quota) begin
         if ($urandom_range(3) == 0)
            send_item(FUNC_CLEAR, $urandom_range(2047), $urandom_range(2047),
                      1'($urandom_range(1)));
         n = $urandom_range(2, 6);
         for (k = 0; k < n; k++) begin
            row_of[k] = cur_base + $urandom_range(11);
            col_of[k] = ($urandom_range(3) == 0) ? row_of[k] : cur_base + $urandom_range(11);
         end
         for (k = 0; k < n; k++) send_item(FUNC_COUNT, row_of[k], col_of[k], k == n - 1);
         // hold the sender until the count pass has fully drained
         if (first_batch && with_pause) wait_idle();
         // start the long receiver hold-off just ahead of the emit burst
         if (first_batch && with_hold_off) hold_requests <= hold_requests + 1;
         for (k = 0; k < n; k++) send_item(FUNC_EMIT, row_of[k], col_of[k], k == n - 1);
         if ($urandom_range(2) == 0) send_stray_item();
         first_batch = 1'b0;
      end
   endtask

   function automatic logic [3:0] pick_block_size();
      return ($urandom_range(4) == 0) ? 4'd8 : 4'($urandom_range(1, 3));
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset         <= 1'b0;
      send_idle_pct <= 7;
      recv_idle_pct <= 59;

      // Directed, on register defaults: block 1, base 0, column-only counting.
      send_item(FUNC_COUNT, 0, 1, 1'b0);
      send_item(FUNC_COUNT, 1, 1, 1'b0);
      send_item(FUNC_COUNT, 1024, 0, 1'b0);       // one past the top vertex
      send_item(FUNC_COUNT, 2047, 2047, 1'b1);
      send_item(FUNC_EMIT, 1, 1, 1'b0);
      send_item(FUNC_EMIT, 0, 1, 1'b0);
      send_item(FUNC_UNUSED, 2047, 0, 1'b1);
      send_item(FUNC_EMIT, 1023, 1023, 1'b1);
      send_item(FUNC_CLEAR, 0, 0, 1'b1);
      wait_idle();

      // Extremes: max gains, block 8, base one, symmetric counting.
      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd8, 1'b1, 1'b1);
      send_item(FUNC_COUNT, 0, 5, 1'b0);          // row below the base
      send_item(FUNC_COUNT, 5, 0, 1'b0);          // column below the base
      send_item(FUNC_COUNT, 1025, 3, 1'b0);
      send_item(FUNC_COUNT, 1024, 1024, 1'b0);    // top vertex under base one
      send_item(FUNC_COUNT, 3, 1024, 1'b1);
      send_item(FUNC_EMIT, 1024, 1024, 1'b0);
      send_item(FUNC_EMIT, 3, 1024, 1'b1);
      send_item(FUNC_EMIT, 0, 0, 1'b1);
      wait_idle();

      // Block size zero clamps to one; minimum gains.
      program_regs(32'd1, 32'd1, 4'd0, 1'b0, 1'b0);
      send_item(FUNC_COUNT, 2, 2, 1'b0);
      send_item(FUNC_COUNT, 2, 3, 1'b1);
      send_item(FUNC_EMIT, 2, 2, 1'b0);
      send_item(FUNC_EMIT, 3, 2, 1'b1);
      wait_idle();

      // Block size fifteen clamps to eight.
      program_regs(ALPHA_GAIN_RESET, BETA_OFFSET_RESET, 4'd15, 1'b0, 1'b1);
      send_item(FUNC_COUNT, 7, 6, 1'b1);
      send_item(FUNC_EMIT, 6, 6, 1'b1);
      send_item(FUNC_CLEAR, 1, 2, 1'b0);
      wait_idle();

      // Random, sender mostly busy and receiver stalling often, with a hold-off.
      program_regs(pick_gain(), pick_gain(), pick_block_size(), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      run_edge_batches(24, 1'b1, 1'b0);
      wait_idle();

      // Random, roles swapped, with a full drain after the first count pass.
      send_idle_pct <= 59;
      recv_idle_pct <= 7;
      program_regs(pick_gain(), pick_gain(), pick_block_size(), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      run_edge_batches(24, 1'b0, 1'b1);
      wait_idle();

      // Random, no idling on either side.
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      program_regs(pick_gain(), pick_gain(), pick_block_size(), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      run_edge_batches(22, 1'b0, 1'b0);
      wait_idle();

      // Full-scale gain at block eight: repeated diagonal counts on one vertex,
      // then its diagonal block and a neighboring off-diagonal block.
      program_regs(32'hFFFF_FFFF, pick_gain(), 4'd8, 1'b0, 1'b1);
      send_item(FUNC_CLEAR, 0, 0, 1'b0);
      repeat (4) send_item(FUNC_COUNT, 9, 9, 1'b0);
      send_item(FUNC_COUNT, 9, 8, 1'b1);
      send_item(FUNC_EMIT, 9, 9, 1'b0);
      send_item(FUNC_EMIT, 8, 9, 1'b1);
      wait_idle();
      repeat (16) @(posedge clock);

      $display("run covered %0d request and %0d result transactions over %0d cycles",
               items_sent, result_count, cycle_count);
      $display("mix: clamped block sizes, both index bases, symmetric counting, range errors");
      if (fail_count == 0)
         $display("graph_laplacian_value_generator regression: pass");
      else
         $display("graph_laplacian_value_generator regression: fail");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/glvg_pkg.sv
rtl/core/glvg_ram.sv
rtl/core/graph_laplacian_value_generator.sv
dv/glvg_value_checker.sv
dv/tb_top.sv
